FILE: src/smbios_rw_pkg.sv
// shared types and constants of the smbios record walker
package smbios_rw_pkg;

	// header size and end-of-table record type
	localparam logic [7:0] HDR_BYTES = 8'd4;
	localparam logic [7:0] END_TYPE = 8'd127;

	// configuration register indexes
	localparam logic [7:0] REG_WANTED_TYPE = 8'd0;
	localparam logic [7:0] REG_WANTED_STRING = 8'd1;
	localparam logic [7:0] REG_STOP_AT_END = 8'd2;

	// output tdata width, padded to whole bytes
	localparam int OUT_DATA_W = 32;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_FORMATTED = 2'd1,
		PH_STRINGS = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] wanted_type;
		logic [7:0] wanted_string;
		logic stop_at_end_type;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic [7:0] offset_count;
		logic [7:0] record_length;
		logic [7:0] current_kind;
		logic [7:0] string_count;
		logic prev_nul;
	} walk_state_t;

	typedef struct packed {
		logic record_start;
		logic [7:0] record_kind;
		logic type_match;
		logic [7:0] field_offset;
		logic [7:0] string_number;
		logic wanted_byte;
		logic record_end;
		logic bad_record;
		logic walk_done;
	} result_t;

endpackage

FILE: src/smbios_rw_frame.sv
// framing state and per-byte result logic of the record walker
module smbios_rw_frame
	import smbios_rw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] table_byte,
	input logic last_of_table,
	input cfg_t cfg,
	output result_t res
);

	walk_state_t st_q;
	walk_state_t st_nxt;

	logic [7:0] kind_v;
	logic [7:0] len_v;
	logic match_v;

	// state register, advanced on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_HEADER, default: '0};
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	// next state and result of the current byte
	always_comb begin
		st_nxt = st_q;
		res = '0;
		kind_v = (st_q.offset_count == 8'd0) ? table_byte : st_q.current_kind;
		len_v = (st_q.offset_count == 8'd1) ? table_byte : st_q.record_length;
		match_v = 1'b0;
		unique case (st_q.phase)
			PH_DONE: begin
				res.walk_done = 1'b1;
			end
			PH_HEADER, PH_FORMATTED: begin
				match_v = (kind_v == cfg.wanted_type);
				st_nxt.current_kind = kind_v;
				res.record_start = (st_q.offset_count == 8'd0);
				res.record_kind = kind_v;
				res.type_match = match_v;
				res.field_offset = st_q.offset_count;
				if (st_q.offset_count == 8'd0 && cfg.stop_at_end_type
						&& table_byte == END_TYPE) begin
					res.walk_done = 1'b1;
					st_nxt.phase = PH_DONE;
				end else if (st_q.offset_count == 8'd1 && table_byte < HDR_BYTES) begin
					st_nxt.record_length = table_byte;
					res.bad_record = 1'b1;
					res.walk_done = 1'b1;
					st_nxt.phase = PH_DONE;
				end else begin
					st_nxt.record_length = len_v;
					// formatted area ends at the last byte counted by length
					if (st_q.offset_count >= (HDR_BYTES - 8'd1)
							&& ({1'b0, st_q.offset_count} + 9'd1) >= {1'b0, len_v}) begin
						st_nxt.phase = PH_STRINGS;
						st_nxt.offset_count = 8'd0;
						st_nxt.string_count = 8'd1;
						st_nxt.prev_nul = 1'b0;
					end else begin
						st_nxt.offset_count = st_q.offset_count + 8'd1;
						st_nxt.phase = ((st_q.offset_count + 8'd1) >= HDR_BYTES)
							? PH_FORMATTED : PH_HEADER;
					end
				end
			end
			PH_STRINGS: begin
				match_v = (st_q.current_kind == cfg.wanted_type);
				res.record_kind = st_q.current_kind;
				res.type_match = match_v;
				res.string_number = st_q.string_count;
				if (table_byte != 8'd0) begin
					res.wanted_byte = match_v && (cfg.wanted_string != 8'd0)
						&& (st_q.string_count == cfg.wanted_string);
					st_nxt.prev_nul = 1'b0;
				end else if (st_q.prev_nul) begin
					// double nul closes the record
					res.record_end = 1'b1;
					st_nxt.phase = PH_HEADER;
					st_nxt.offset_count = 8'd0;
					st_nxt.string_count = 8'd0;
					st_nxt.prev_nul = 1'b0;
				end else begin
					st_nxt.prev_nul = 1'b1;
					if (st_q.string_count != 8'hff) begin
						st_nxt.string_count = st_q.string_count + 8'd1;
					end
				end
			end
			default: begin
				res.walk_done = 1'b1;
			end
		endcase
		// end of table range restarts the walk
		if (last_of_table) begin
			res.walk_done = 1'b1;
			st_nxt = '{phase: PH_HEADER, default: '0};
		end
	end

endmodule

FILE: src/smbios_rw_outreg.sv
// result register between the framing logic and the output stream
module smbios_rw_outreg
	import smbios_rw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic load,
	input result_t res,
	input logic m_tready,
	output logic m_tvalid,
	output logic full_stall,
	output result_t res_q
);

	logic valid_q;

	// valid flag: set on load, cleared when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign full_stall = valid_q && !m_tready;

endmodule

FILE: src/smbios_record_walker_core.sv
// top level of the smbios structure table record walker
// an accepted table byte has its result on the output register in the cycle after it is accepted
// throughput: one byte per cycle; a new byte is taken whenever the output register
// is empty or its result is taken in the same cycle
// reset: arst_n clears the walk state and output valid, registers return to
// wanted_type 0, wanted_string 0, stop_at_end_type 1
module smbios_record_walker_core
	import smbios_rw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	// table byte stream
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // table_byte
	input logic s_tlast, // last_of_table
	// result stream
	output logic m_tvalid,
	input logic m_tready,
	// record_start[0], record_kind[8:1], type_match[9], field_offset[17:10],
	// string_number[25:18], wanted_byte[26], bad_record[27], walk_done[28], zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic m_tlast, // record_end
	// configuration writes
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [7:0] cfg_data
);

	cfg_t cfg_q;
	result_t res;
	result_t res_q;
	logic accept;
	logic full_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{wanted_type: 8'd0, wanted_string: 8'd0, stop_at_end_type: 1'b1};
		end else if (cfg_valid) begin
			if (cfg_index == REG_WANTED_TYPE) begin
				cfg_q.wanted_type <= cfg_data;
			end
			if (cfg_index == REG_WANTED_STRING) begin
				cfg_q.wanted_string <= cfg_data;
			end
			if (cfg_index == REG_STOP_AT_END) begin
				cfg_q.stop_at_end_type <= cfg_data[0];
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready = !full_stall;
	assign accept = s_tvalid && s_tready;

	smbios_rw_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.table_byte(s_tdata),
		.last_of_table(s_tlast),
		.cfg(cfg_q),
		.res(res)
	);

	smbios_rw_outreg u_outreg (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.res(res),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.full_stall(full_stall),
		.res_q(res_q)
	);

	// output packing
	assign m_tdata = {3'b000, res_q.walk_done, res_q.bad_record, res_q.wanted_byte,
		res_q.string_number, res_q.field_offset, res_q.type_match,
		res_q.record_kind, res_q.record_start};
	assign m_tlast = res_q.record_end;

endmodule

FILE: src/smbios_rw_checker.sv
// port-level assertions for the record walker, bound to the top level
module smbios_rw_checker
	import smbios_rw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic m_tlast
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// a bad length always stops the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[27] |-> m_tdata[28])
		else $error("bad record without walk done");

	// a record start lies at offset zero outside the string set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[17:10] == 8'd0 && m_tdata[25:18] == 8'd0)
		else $error("record start with offset or string number");

	// a wanted byte belongs to a matching record and a numbered string
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[26] |-> m_tdata[9] && m_tdata[25:18] != 8'd0)
		else $error("wanted byte outside matching string");

	// a record end comes from the string set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[25:18] != 8'd0 && m_tdata[0] == 1'b0)
		else $error("record end outside string set");

endmodule

bind smbios_record_walker_core smbios_rw_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);

FILE: bench/smbios_record_walker_core_test.sv
// testbench of the smbios record walker: random tables against a cycle-free walk predictor
`timescale 1ns / 1ps

module smbios_record_walker_core_test;
	import smbios_rw_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_CYCLES = 400;

	// expected walk results, kept in acceptance order
	class walk_scoreboard;
		logic [7:0] wanted_type;
		logic [7:0] wanted_string;
		logic stop_at_end;
		phase_t phase;
		logic [7:0] offset_count;
		logic [7:0] record_length;
		logic [7:0] current_kind;
		logic [7:0] string_count;
		logic prev_nul;
		result_t expected_q[$];
		int errors;

		function new();
			wanted_type = 8'd0;
			wanted_string = 8'd0;
			stop_at_end = 1'b1;
			errors = 0;
			restart_walk();
		endfunction

		function void restart_walk();
			phase = PH_HEADER;
			offset_count = 8'd0;
			record_length = 8'd0;
			current_kind = 8'd0;
			string_count = 8'd0;
			prev_nul = 1'b0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [7:0] val);
			case (idx)
				REG_WANTED_TYPE: wanted_type = val;
				REG_WANTED_STRING: wanted_string = val;
				REG_STOP_AT_END: stop_at_end = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// predict the result of one accepted byte; returns 1 when the walk was live
		function bit note_byte(logic [7:0] b, logic last);
			result_t r;
			logic [7:0] o;
			bit live;
			r = '0;
			o = offset_count;
			live = (phase != PH_DONE);
			if (phase == PH_DONE) begin
				r.walk_done = 1'b1;
			end else if (phase == PH_HEADER || phase == PH_FORMATTED) begin
				if (o == 8'd0) begin
					current_kind = b;
					r.record_start = 1'b1;
				end
				r.record_kind = current_kind;
				r.type_match = (current_kind == wanted_type);
				r.field_offset = o;
				if (o == 8'd0 && stop_at_end && b == END_TYPE) begin
					// end-of-table type stops the walk
					r.walk_done = 1'b1;
					phase = PH_DONE;
				end else if (o == 8'd1 && b < HDR_BYTES) begin
					// header length too short
					record_length = b;
					r.bad_record = 1'b1;
					r.walk_done = 1'b1;
					phase = PH_DONE;
				end else begin
					if (o == 8'd1)
						record_length = b;
					if (o >= HDR_BYTES - 8'd1 && int'(o) + 1 >= int'(record_length)) begin
						phase = PH_STRINGS;
						offset_count = 8'd0;
						string_count = 8'd1;
						prev_nul = 1'b0;
					end else begin
						offset_count = o + 8'd1;
						phase = (offset_count >= HDR_BYTES) ? PH_FORMATTED : PH_HEADER;
					end
				end
			end else begin
				// string set
				r.record_kind = current_kind;
				r.type_match = (current_kind == wanted_type);
				r.string_number = string_count;
				if (b != 8'd0) begin
					r.wanted_byte = r.type_match && wanted_string != 8'd0
						&& string_count == wanted_string;
					prev_nul = 1'b0;
				end else if (prev_nul) begin
					r.record_end = 1'b1;
					phase = PH_HEADER;
					offset_count = 8'd0;
					string_count = 8'd0;
					prev_nul = 1'b0;
				end else begin
					prev_nul = 1'b1;
					if (string_count < 8'd255)
						string_count = string_count + 8'd1;
				end
			end
			if (last) begin
				r.walk_done = 1'b1;
				restart_walk();
			end
			expected_q.push_back(r);
			return live;
		endfunction

		function void field_cmp(string name, int exp_val, int act_val);
			if (exp_val != act_val) begin
				$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(logic [OUT_DATA_W-1:0] data, logic rend);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no prediction waiting: tdata %h", data);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			field_cmp("record_start", int'(e.record_start), int'(data[0]));
			field_cmp("record_kind", int'(e.record_kind), int'(data[8:1]));
			field_cmp("type_match", int'(e.type_match), int'(data[9]));
			field_cmp("field_offset", int'(e.field_offset), int'(data[17:10]));
			field_cmp("string_number", int'(e.string_number), int'(data[25:18]));
			field_cmp("wanted_byte", int'(e.wanted_byte), int'(data[26]));
			field_cmp("bad_record", int'(e.bad_record), int'(data[27]));
			field_cmp("walk_done", int'(e.walk_done), int'(data[28]));
			field_cmp("record_end", int'(e.record_end), int'(rend));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = 8'd0;
	logic [7:0] cfg_data = 8'd0;

	walk_scoreboard sb = new();
	int cycle_count = 0;
	int live_items = 0;
	bit burst_mode = 1'b0;
	bit hold_req = 1'b0;
	logic [7:0] cur_wanted_type = 8'd0;

	smbios_record_walker_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("smbios_record_walker_core_test: done, errors");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result receiver with random stalls and one long hold-off on request
	initial begin
		int stall;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = gap_len();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 30)) @(posedge clk);
		end
	end

	// send one table byte and record its prediction
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = burst_mode ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		if (sb.note_byte(b, last))
			live_items++;
	endtask

	task automatic send_table(ref logic [7:0] q[$], input bit with_last);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], with_last && i == q.size() - 1);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// write all three registers; the block is idle here
	task automatic write_regs(input logic [7:0] wt, input logic [7:0] ws, input logic stop);
		logic [7:0] vals [3];
		logic [7:0] idxs [3];
		vals = '{wt, ws, {7'd0, stop}};
		idxs = '{REG_WANTED_TYPE, REG_WANTED_STRING, REG_STOP_AT_END};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idxs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		cur_wanted_type = wt;
	endtask

	// append one record: header, formatted area, string set
	task automatic add_record(ref logic [7:0] q[$], input logic [7:0] kind,
			input logic [7:0] len, input int nstr, input int maxchars);
		int nchars;
		q.push_back(kind);
		q.push_back(len);
		q.push_back(8'($urandom_range(0, 255)));
		q.push_back(8'($urandom_range(0, 255)));
		for (int i = 4; i < len; i++)
			q.push_back(8'($urandom_range(0, 255)));
		if (nstr == 0)
			q.push_back(8'd0);
		for (int s = 0; s < nstr; s++) begin
			nchars = $urandom_range(1, maxchars);
			for (int c = 0; c < nchars; c++)
				q.push_back(8'($urandom_range(1, 255)));
			q.push_back(8'd0);
		end
		q.push_back(8'd0);
	endtask

	function automatic logic [7:0] pick_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return cur_wanted_type;
		if (r == 8)
			return END_TYPE;
		if (r == 9)
			return 8'd0;
		if (r == 10)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 8'($urandom_range(0, 3));
		if (r < 7)
			return 8'd255;
		return 8'($urandom_range(4, 24));
	endfunction

	// one random table: mostly well-formed records, some truncated or noise
	task automatic random_table();
		logic [7:0] q[$];
		int r;
		bit with_last;
		burst_mode = ($urandom_range(0, 9) < 3);
		r = $urandom_range(0, 99);
		if (r < 5) begin
			repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
			with_last = 1'($urandom_range(0, 1));
		end else begin
			repeat ($urandom_range(1, 5))
				add_record(q, pick_kind(), pick_length(), $urandom_range(0, 5), 6);
			with_last = ($urandom_range(0, 99) < 85);
			if (r < 15) begin
				q = q[0:$urandom_range(0, q.size() - 1)];
				with_last = 1'b1;
			end
		end
		send_table(q, with_last);
	endtask

	initial begin
		logic [7:0] q[$];
		int phase_idx;
		int phase_start;
		logic [7:0] ws;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default registers, matching type 0, empty string set
		add_record(q, 8'd0, 8'd4, 0, 1);
		send_table(q, 1'b0);
		wait_idle();
		write_regs(8'd255, 8'd1, 1'b1);
		// matching record with one wanted string and one extra formatted byte
		q = {8'hFF, 8'd5, 8'h00, 8'hFF, 8'h80, 8'h41, 8'hFF, 8'h00, 8'h00};
		send_table(q, 1'b0);
		// end-of-table type stops the walk, range end restarts it
		q = {END_TYPE, 8'h80};
		send_table(q, 1'b1);
		// short header length
		q = {8'h01, 8'h03, 8'h55};
		send_table(q, 1'b1);
		// range end in the middle of a record
		q = {8'h02, 8'h08, 8'h00};
		send_table(q, 1'b1);
		wait_idle();

		// random phases under several register settings
		live_items = 0;
		phase_idx = 0;
		while (live_items < RANDOM_ITEMS) begin
			ws = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 5));
			case (phase_idx)
				0: write_regs(8'd0, 8'd0, 1'b0);
				1: write_regs(8'd255, 8'd255, 1'b1);
				2: write_regs(END_TYPE, 8'd1, 1'b0);
				default: write_regs(8'($urandom_range(0, 255)), ws,
					1'($urandom_range(0, 1)));
			endcase
			if (phase_idx == 0)
				hold_req = 1'b1;
			if (phase_idx == 1) begin
				// string count runs into saturation in a matching record
				q.delete();
				add_record(q, 8'd255, 8'd4, 257, 1);
				send_table(q, 1'b1);
			end
			phase_start = live_items;
			while (live_items - phase_start < PHASE_ITEMS)
				random_table();
			wait_idle();
			phase_idx++;
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("smbios_record_walker_core_test: done, clean");
		else
			$display("smbios_record_walker_core_test: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
src/smbios_rw_pkg.sv
src/smbios_rw_frame.sv
src/smbios_rw_outreg.sv
src/smbios_record_walker_core.sv
src/smbios_rw_checker.sv
bench/smbios_record_walker_core_test.sv
